[design/fuyd_pkg.sv]
// ----------------------------------------------------------------------------
// fuyd_pkg: shared types and constants of the yaw frame deframer
// Event codes, register indexes, result record and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package fuyd_pkg;

    localparam int NUM_GROUPS = 10;
    localparam int RAW_KEPT   = 7;
    localparam int POS_W      = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] CFG_FRAME_TYPE = 8'd0;
    localparam logic [7:0] CFG_FLAGS_MASK = 8'd1;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_ACCEPT    = 3'd1,
        EV_BAD_CRC   = 3'd2,
        EV_BAD_FLAGS = 3'd3,
        EV_UNKNOWN   = 3'd4
    } t_event;

    typedef struct packed {
        t_event             event_res;
        logic               restarted;
        logic [7:0]         seq;
        logic [7:0]         target_seq;
        logic [7:0]         frame_flags;
        logic [7:0]         source_age_ms;
        logic signed [15:0] yaw_q;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] din);
        logic [15:0] crc;
        crc = crc_in ^ {din, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

[design/fuyd_frame_engine.sv]
// ----------------------------------------------------------------------------
// fuyd_frame_engine: frame state, 7-bit unpacking and running CRC
// Processes one byte per step; raw bytes and the CRC are built as groups arrive.
// ----------------------------------------------------------------------------
module fuyd_frame_engine
    import fuyd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic [6:0] i_frame_type,
    input  logic [7:0] i_flags_mask,
    output t_result    o_result
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_GROUPS - 1);
    localparam logic [POS_W-1:0] CRC_LAST = POS_W'(6);
    localparam logic [POS_W-1:0] RAW_LAST = POS_W'(RAW_KEPT);

    logic             r_open, n_open;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [6:0]       r_prev, n_prev;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_raw [0:RAW_KEPT-1];

    logic [6:0]  group;
    logic [13:0] window;
    logic [2:0]  shift;
    logic [7:0]  raw_new;
    logic [2:0]  raw_idx;
    logic        raw_we;
    logic [15:0] crc_sel;
    logic [7:0]  crc_din;
    logic [15:0] crc_out;
    logic [15:0] rx_crc;
    t_result     res;

    always_comb begin
        n_open  = r_open;
        n_pos   = r_pos;
        n_prev  = r_prev;
        n_crc   = r_crc;
        raw_we  = 1'b0;
        res     = '0;
        res.event_res = EV_NONE;

        group   = i_byte[6:0];
        window  = {r_prev, group};
        shift   = (r_pos == LAST_POS) ? 3'd6 : 3'(3'd7 - r_pos[2:0]);
        raw_new = 8'(window >> shift);
        raw_idx = 3'(r_pos[2:0] - 3'd1);
        crc_sel = i_byte[7] ? CRC_INIT : r_crc;
        crc_din = i_byte[7] ? i_byte : raw_new;
        crc_out = crc_byte(crc_sel, crc_din);
        rx_crc  = {r_raw[RAW_KEPT-1], raw_new};

        if (i_byte[7]) begin
            res.restarted = r_open;
            n_pos = '0;
            if (i_byte[6:0] == i_frame_type) begin
                n_open = 1'b1;
                n_crc  = crc_out;
            end else begin
                n_open = 1'b0;
                res.event_res = EV_UNKNOWN;
            end
        end else if (r_open) begin
            n_prev = group;
            n_pos  = POS_W'(r_pos + 1'b1);
            if (r_pos != '0 && r_pos <= CRC_LAST) begin
                n_crc = crc_out;
            end
            if (r_pos != '0 && r_pos <= RAW_LAST) begin
                raw_we = 1'b1;
            end
            if (r_pos == LAST_POS) begin
                n_open = 1'b0;
                n_pos  = '0;
                if (rx_crc != r_crc) begin
                    res.event_res = EV_BAD_CRC;
                end else if ((r_raw[2] & ~i_flags_mask) != 8'h00) begin
                    res.event_res = EV_BAD_FLAGS;
                end else begin
                    res.event_res     = EV_ACCEPT;
                    res.seq           = r_raw[0];
                    res.target_seq    = r_raw[1];
                    res.frame_flags   = r_raw[2];
                    res.source_age_ms = r_raw[3];
                    res.yaw_q         = {r_raw[4], r_raw[5]};
                end
            end
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_pos  <= '0;
        end else if (i_step) begin
            r_open <= n_open;
            r_pos  <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_prev <= n_prev;
            r_crc  <= n_crc;
            if (raw_we) begin
                r_raw[raw_idx] <= raw_new;
            end
        end
    end

endmodule

[design/framed_uart_yaw_deframer.sv]
// ----------------------------------------------------------------------------
// framed_uart_yaw_deframer: 7-bit packed yaw frame receiver
// Byte stream in, one status/result transaction out per byte.
// ----------------------------------------------------------------------------
// Slave stream: one received UART byte per transaction (s_axis_tdata).
// Master stream: exactly one transaction per input byte. tuser carries the
// event code and the restart flag; tdata carries the frame fields, which are
// zero unless the event is a accepted frame.
// Config channel: index 0 frame type, index 1 known flags mask; other
// indexes are ignored. Always ready; write only while the stream is idle.
// Path: the byte is held in the input register, then its decode result is
// registered into the output register, which drives the output transaction.
// Throughput: one byte per cycle while the output is taken; the decode stage
// (CRC byte update and group unpack) is combinational.
// Reset: no frame open, config registers at their defaults, both stages empty.
// Stall: while the output is held, one more byte is taken into the input
// register; then s_axis_tready drops until the output is taken.
// ----------------------------------------------------------------------------
module framed_uart_yaw_deframer
    import fuyd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] seq, [15:8] target_seq,
                                        // [23:16] frame_flags,
                                        // [31:24] source_age_ms, [47:32] yaw_q
    output logic [3:0]  m_axis_tuser,   // [2:0] event_res, [3] restarted
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic [6:0] r_frame_type;
    logic [7:0] r_flags_mask;

    logic    out_free;
    logic    step;
    t_result result;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign o_cfg_ready   = 1'b1;

    fuyd_frame_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_frame_type (r_frame_type),
        .i_flags_mask (r_flags_mask),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_type <= 7'h10;
            r_flags_mask <= 8'h07;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_TYPE: r_frame_type <= i_cfg_data[6:0];
                CFG_FLAGS_MASK: r_flags_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (step) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out.restarted, r_out.event_res};
    assign m_axis_tdata  = {r_out.yaw_q, r_out.source_age_ms, r_out.frame_flags,
                            r_out.target_seq, r_out.seq};

endmodule

[design/fuyd_checker.sv]
// ----------------------------------------------------------------------------
// fuyd_checker: port-level checks of the yaw frame deframer
// Watches the output stream over time; bound to the top level.
// ----------------------------------------------------------------------------
module fuyd_checker
    import fuyd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled transaction changed");

    a_data_only_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:0] != EV_ACCEPT |-> m_axis_tdata == '0)
        else $error("frame data on non-accept event");

    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[2:0] == EV_NONE || m_axis_tuser[2:0] == EV_ACCEPT
            || m_axis_tuser[2:0] == EV_BAD_CRC || m_axis_tuser[2:0] == EV_BAD_FLAGS
            || m_axis_tuser[2:0] == EV_UNKNOWN)
        else $error("event code out of range");

    a_restart_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3] |->
            m_axis_tuser[2:0] == EV_NONE || m_axis_tuser[2:0] == EV_UNKNOWN)
        else $error("restart flag on frame completion");

endmodule

bind framed_uart_yaw_deframer fuyd_checker u_fuyd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
